// ===== src/shp_pkg.sv =====
// Shared types and constants of the sync-header frame parser.
package shp_pkg;

   localparam logic [7:0]  SYNC_BYTE     = 8'hAA;
   localparam logic [15:0] MAX_LEN_RESET = 16'd256;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_GOOD = 2'd1,
      KIND_BAD  = 2'd2,
      KIND_DROP = 2'd3
   } kind_type;

   typedef enum logic [11:0] {
      PH_SYNC0  = 12'b0000_0000_0001,
      PH_SYNC1  = 12'b0000_0000_0010,
      PH_SYNC2  = 12'b0000_0000_0100,
      PH_SYNC3  = 12'b0000_0000_1000,
      PH_ADDR   = 12'b0000_0001_0000,
      PH_CMD    = 12'b0000_0010_0000,
      PH_OFS_LO = 12'b0000_0100_0000,
      PH_OFS_HI = 12'b0000_1000_0000,
      PH_LEN_LO = 12'b0001_0000_0000,
      PH_LEN_HI = 12'b0010_0000_0000,
      PH_DATA   = 12'b0100_0000_0000,
      PH_SUM    = 12'b1000_0000_0000
   } phase_type;

   typedef struct packed {
      logic [15:0] payload_length;
      logic [15:0] frame_offset;
      logic [7:0]  command_code;
      logic [7:0]  device_address;
      logic [15:0] byte_index;
      logic [7:0]  payload_byte;
   } result_type;

endpackage

// ===== src/shp_core.sv =====
// Parse state machine, header field capture and checksum of the frame parser.
module shp_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         rx_byte,
   input  logic [15:0]        max_len,
   output logic               has_result,
   output shp_pkg::kind_type  result_kind,
   output shp_pkg::result_type result
);

   shp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  address_ff, address_in;
   logic [7:0]  command_ff, command_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic [15:0] count_next;
   logic        is_sync;

   assign is_sync    = (rx_byte == shp_pkg::SYNC_BYTE);
   assign count_next = count_ff + 16'd1;

   always_comb begin
      phase_in    = phase_ff;
      address_in  = address_ff;
      command_in  = command_ff;
      offset_in   = offset_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      has_result  = 1'b0;
      result_kind = shp_pkg::KIND_DATA;
      result      = '0;

      if (phase_ff inside {shp_pkg::PH_ADDR, shp_pkg::PH_CMD, shp_pkg::PH_OFS_LO,
                           shp_pkg::PH_OFS_HI, shp_pkg::PH_LEN_LO, shp_pkg::PH_LEN_HI,
                           shp_pkg::PH_DATA}) begin
         sum_in = sum_ff + rx_byte;
      end

      case (phase_ff)
         shp_pkg::PH_SYNC1: begin
            phase_in = is_sync ? shp_pkg::PH_SYNC2 : shp_pkg::PH_SYNC0;
         end
         shp_pkg::PH_SYNC2: begin
            phase_in = is_sync ? shp_pkg::PH_SYNC3 : shp_pkg::PH_SYNC0;
         end
         shp_pkg::PH_SYNC3: begin
            if (is_sync) begin
               phase_in = shp_pkg::PH_ADDR;
               sum_in   = 8'd0;
            end else begin
               phase_in = shp_pkg::PH_SYNC0;
            end
         end
         shp_pkg::PH_ADDR: begin
            address_in = rx_byte;
            phase_in   = shp_pkg::PH_CMD;
         end
         shp_pkg::PH_CMD: begin
            command_in = rx_byte;
            phase_in   = shp_pkg::PH_OFS_LO;
         end
         shp_pkg::PH_OFS_LO: begin
            offset_in = {8'd0, rx_byte};
            phase_in  = shp_pkg::PH_OFS_HI;
         end
         shp_pkg::PH_OFS_HI: begin
            offset_in = {rx_byte, offset_ff[7:0]};
            phase_in  = shp_pkg::PH_LEN_LO;
         end
         shp_pkg::PH_LEN_LO: begin
            length_in = {8'd0, rx_byte};
            phase_in  = shp_pkg::PH_LEN_HI;
         end
         shp_pkg::PH_LEN_HI: begin
            length_in = {rx_byte, length_ff[7:0]};
            if (length_in > max_len) begin
               has_result  = 1'b1;
               result_kind = shp_pkg::KIND_DROP;
               phase_in    = shp_pkg::PH_SYNC0;
            end else if (length_in == 16'd0) begin
               phase_in = shp_pkg::PH_SUM;
            end else begin
               count_in = 16'd0;
               phase_in = shp_pkg::PH_DATA;
            end
         end
         shp_pkg::PH_DATA: begin
            has_result          = 1'b1;
            result_kind         = shp_pkg::KIND_DATA;
            result.payload_byte = rx_byte;
            result.byte_index   = count_ff;
            count_in            = count_next;
            if (count_next >= length_ff) begin
               phase_in = shp_pkg::PH_SUM;
            end
         end
         shp_pkg::PH_SUM: begin
            has_result  = 1'b1;
            result_kind = (rx_byte == sum_ff) ? shp_pkg::KIND_GOOD : shp_pkg::KIND_BAD;
            phase_in    = shp_pkg::PH_SYNC0;
         end
         default: begin
            phase_in = is_sync ? shp_pkg::PH_SYNC1 : shp_pkg::PH_SYNC0;
         end
      endcase

      result.device_address = address_in;
      result.command_code   = command_in;
      result.frame_offset   = offset_in;
      result.payload_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= shp_pkg::PH_SYNC0;
         address_ff <= 8'd0;
         command_ff <= 8'd0;
         offset_ff  <= 16'd0;
         length_ff  <= 16'd0;
         count_ff   <= 16'd0;
         sum_ff     <= 8'd0;
      end else if (step) begin
         phase_ff   <= phase_in;
         address_ff <= address_in;
         command_ff <= command_in;
         offset_ff  <= offset_in;
         length_ff  <= length_in;
         count_ff   <= count_in;
         sum_ff     <= sum_in;
      end
   end

endmodule

// ===== src/shp_out_reg.sv =====
// Result register of the frame parser, holding one word for the output stream.
module shp_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  shp_pkg::kind_type   load_kind,
   input  shp_pkg::result_type load_result,
   output logic                free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [71:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser
);

   logic                valid_ff, valid_in;
   shp_pkg::kind_type   kind_ff;
   shp_pkg::result_type result_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= load_kind;
         result_ff <= load_result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = result_ff;
   assign rsp_tuser  = kind_ff;

endmodule

// ===== src/sync_header_frame_parser.sv =====
// Sync-header frame parser top level: input register, parser core and result register.
// The parser takes one received byte per word and accepts a word in every clock cycle
// as long as the result register is empty, being taken, or the byte produces no result.
// Each byte passes the input register and then the result register, which presents
// its result word unless the byte yields none. After four 0xAA sync bytes the parser
// reads address, command, little-endian offset and little-endian length; a length above
// the configured maximum yields one drop word, otherwise each payload byte yields one
// data word and the checksum byte yields a good or bad verdict carrying the header fields.
// The maximum length register should only be written while no byte is in flight.
module sync_header_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // payload_byte, byte_index, device_address, command_code, frame_offset, payload_length
   output logic [71:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // kind
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data  // max_payload_len
);

   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_byte_ff;
   logic [15:0]         max_len_ff;
   logic                advance;
   logic                out_free;
   logic                has_result;
   shp_pkg::kind_type   result_kind;
   shp_pkg::result_type result;

   assign advance     = s1_valid_ff && (out_free || !has_result);
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         max_len_ff  <= shp_pkg::MAX_LEN_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
      end
   end

   shp_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (s1_byte_ff),
      .max_len     (max_len_ff),
      .has_result  (has_result),
      .result_kind (result_kind),
      .result      (result)
   );

   shp_out_reg u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && has_result),
      .load_kind   (result_kind),
      .load_result (result),
      .free        (out_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && has_result) |-> (!rsp_tvalid || rsp_tready))
      else $error("A result was loaded over one not yet taken.");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("The input side is not ready after reset.");

   a_verdict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != shp_pkg::KIND_DATA) |-> (rsp_tdata[23:0] == 24'd0))
      else $error("A verdict word carries a payload byte or index.");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == shp_pkg::KIND_DATA) |-> (rsp_tdata[23:8] < rsp_tdata[71:56]))
      else $error("A payload index lies beyond the frame length.");

endmodule

// ===== tb/sync_header_frame_parser_tb.sv =====
// Self-checking testbench for the sync-header frame parser.
`timescale 1ns / 100ps

module sync_header_frame_parser_tb;

   localparam logic [7:0] SYNC = shp_pkg::SYNC_BYTE;
   localparam int PHASE_BYTES = 270;

   typedef enum logic [3:0] {
      SEEK0, SEEK1, SEEK2, SEEK3,
      GET_ADDR, GET_CMD, GET_OFS_LO, GET_OFS_HI,
      GET_LEN_LO, GET_LEN_HI, GET_DATA, GET_SUM
   } stage_type;

   typedef struct packed {
      shp_pkg::kind_type   kind;
      shp_pkg::result_type body;
   } parse_word_type;

   typedef struct packed {
      logic [7:0]        rx;
      bit                pinned;
      shp_pkg::kind_type kind;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;

   // Parser state as predicted from the accepted bytes.
   stage_type   stage = SEEK0;
   logic [7:0]  hdr_addr = '0;
   logic [7:0]  hdr_cmd = '0;
   logic [15:0] hdr_ofs = '0;
   logic [15:0] hdr_len = '0;
   logic [15:0] data_count = '0;
   logic [7:0]  byte_sum = '0;
   logic [15:0] len_limit = shp_pkg::MAX_LEN_RESET;

   parse_word_type expected_words[$];
   int          errors = 0;
   int          bytes_sent = 0;
   int          framed_bytes = 0;
   int          kind_count[4] = '{0, 0, 0, 0};
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // Noise, a broken sync, a zero-length frame at the field extremes and a frame
   // whose length is the largest possible.
   stim_row_type directed_rows [26] = '{
      '{8'h00, 1'b0, shp_pkg::KIND_DATA}, '{8'hFF, 1'b0, shp_pkg::KIND_DATA},
      '{SYNC,  1'b0, shp_pkg::KIND_DATA}, '{SYNC,  1'b0, shp_pkg::KIND_DATA},
      '{8'h00, 1'b0, shp_pkg::KIND_DATA},
      '{SYNC,  1'b0, shp_pkg::KIND_DATA}, '{SYNC,  1'b0, shp_pkg::KIND_DATA},
      '{SYNC,  1'b0, shp_pkg::KIND_DATA}, '{SYNC,  1'b0, shp_pkg::KIND_DATA},
      '{8'hFF, 1'b0, shp_pkg::KIND_DATA}, '{8'h00, 1'b0, shp_pkg::KIND_DATA},
      '{8'hFF, 1'b0, shp_pkg::KIND_DATA}, '{8'hFF, 1'b0, shp_pkg::KIND_DATA},
      '{8'h00, 1'b0, shp_pkg::KIND_DATA}, '{8'h00, 1'b0, shp_pkg::KIND_DATA},
      '{8'hFD, 1'b1, shp_pkg::KIND_GOOD},
      '{SYNC,  1'b0, shp_pkg::KIND_DATA}, '{SYNC,  1'b0, shp_pkg::KIND_DATA},
      '{SYNC,  1'b0, shp_pkg::KIND_DATA}, '{SYNC,  1'b0, shp_pkg::KIND_DATA},
      '{8'h12, 1'b0, shp_pkg::KIND_DATA}, '{8'h34, 1'b0, shp_pkg::KIND_DATA},
      '{8'h00, 1'b0, shp_pkg::KIND_DATA}, '{8'h80, 1'b0, shp_pkg::KIND_DATA},
      '{8'hFF, 1'b0, shp_pkg::KIND_DATA}, '{8'hFF, 1'b1, shp_pkg::KIND_DROP}
   };

   logic [15:0] phase_limits [5] = '{16'd0, 16'hFFFF, 16'd12, 16'd1, 16'd40};
   int unsigned phase_idle [4] = '{0, 50, 0, 34};
   int unsigned phase_stall [4] = '{0, 0, 50, 34};

   sync_header_frame_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic bit parse_byte(input logic [7:0] b, output parse_word_type w);
      bit produced;
      produced = 1'b0;
      w = '0;
      if (stage >= GET_ADDR && stage <= GET_DATA) byte_sum = byte_sum + b;
      case (stage)
         SEEK1, SEEK2: begin
            stage = (b == SYNC) ? stage_type'(stage + 1) : SEEK0;
         end
         SEEK3: begin
            if (b == SYNC) begin
               stage = GET_ADDR;
               byte_sum = '0;
            end else begin
               stage = SEEK0;
            end
         end
         GET_ADDR: begin
            hdr_addr = b;
            stage = GET_CMD;
         end
         GET_CMD: begin
            hdr_cmd = b;
            stage = GET_OFS_LO;
         end
         GET_OFS_LO: begin
            hdr_ofs = {8'h00, b};
            stage = GET_OFS_HI;
         end
         GET_OFS_HI: begin
            hdr_ofs[15:8] = b;
            stage = GET_LEN_LO;
         end
         GET_LEN_LO: begin
            hdr_len = {8'h00, b};
            stage = GET_LEN_HI;
         end
         GET_LEN_HI: begin
            hdr_len[15:8] = b;
            if (hdr_len > len_limit) begin
               w.kind = shp_pkg::KIND_DROP;
               produced = 1'b1;
               stage = SEEK0;
            end else if (hdr_len == 16'd0) begin
               stage = GET_SUM;
            end else begin
               data_count = '0;
               stage = GET_DATA;
            end
         end
         GET_DATA: begin
            w.kind = shp_pkg::KIND_DATA;
            w.body.payload_byte = b;
            w.body.byte_index = data_count;
            produced = 1'b1;
            data_count = data_count + 16'd1;
            if (data_count >= hdr_len) stage = GET_SUM;
         end
         GET_SUM: begin
            w.kind = (b == byte_sum) ? shp_pkg::KIND_GOOD : shp_pkg::KIND_BAD;
            produced = 1'b1;
            stage = SEEK0;
         end
         default: begin
            stage = (b == SYNC) ? SEEK1 : SEEK0;
         end
      endcase
      w.body.device_address = hdr_addr;
      w.body.command_code = hdr_cmd;
      w.body.frame_offset = hdr_ofs;
      w.body.payload_length = hdr_len;
      return produced;
   endfunction

   function automatic logic [15:0] pick_length();
      int unsigned r;
      r = $urandom_range(99);
      if (len_limit != 16'hFFFF && r < 20) begin
         case ($urandom_range(2))
            0: return len_limit + 16'd1;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535, 32'(len_limit) + 1));
         endcase
      end
      if (r < 30 && len_limit <= 16'd64) return len_limit;
      return 16'($urandom_range(len_limit < 16'd16 ? 32'(len_limit) : 16));
   endfunction

   task automatic send_byte(input logic [7:0] b, input bit pinned = 1'b0,
                            input shp_pkg::kind_type pin_kind = shp_pkg::KIND_DATA);
      parse_word_type w;
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (parse_byte(b, w)) begin
         if (pinned) w.kind = pin_kind;
         expected_words.push_back(w);
      end
   endtask

   // Lets every word in flight come out, with the input idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      len_limit = v;
   endtask

   task automatic send_frame();
      logic [7:0]  addr, cmd, sum, b;
      logic [15:0] ofs, len;
      int unsigned r, n;
      r = $urandom_range(99);
      if (r < 6) begin
         n = $urandom_range(4, 1);
         repeat (n) send_byte(8'($urandom_range(255)));
      end else if (r < 12) begin
         n = $urandom_range(3, 1);
         repeat (n) send_byte(SYNC);
         b = 8'($urandom_range(255));
         send_byte(b == SYNC ? 8'h00 : b);
      end else begin
         addr = 8'($urandom);
         cmd = 8'($urandom);
         ofs = 16'($urandom);
         len = pick_length();
         sum = addr + cmd + ofs[7:0] + ofs[15:8] + len[7:0] + len[15:8];
         repeat (4) send_byte(SYNC);
         send_byte(addr);
         send_byte(cmd);
         send_byte(ofs[7:0]);
         send_byte(ofs[15:8]);
         send_byte(len[7:0]);
         send_byte(len[15:8]);
         framed_bytes += 10;
         if (len <= len_limit) begin
            for (int i = 0; i < len; i++) begin
               b = 8'($urandom);
               sum = sum + b;
               send_byte(b);
            end
            if ($urandom_range(3) == 0) sum = sum ^ 8'($urandom_range(255, 1));
            send_byte(sum);
            framed_bytes += len + 1;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch_results
      parse_word_type      want;
      shp_pkg::result_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got = rsp_tdata;
         if (expected_words.size() == 0) begin
            $error("Result word arrived with nothing expected.");
            errors++;
         end else begin
            want = expected_words.pop_front();
            check_field("kind", 16'(want.kind), 16'(rsp_tuser));
            check_field("payload_byte", 16'(want.body.payload_byte), 16'(got.payload_byte));
            check_field("byte_index", want.body.byte_index, got.byte_index);
            check_field("device_address", 16'(want.body.device_address),
                        16'(got.device_address));
            check_field("command_code", 16'(want.body.command_code),
                        16'(got.command_code));
            check_field("frame_offset", want.body.frame_offset, got.frame_offset);
            check_field("payload_length", want.body.payload_length, got.payload_length);
            kind_count[want.kind]++;
         end
      end
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      int start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].pinned, directed_rows[i].kind);
      for (int p = 0; p < 5; p++) begin
         drain();
         write_limit(phase_limits[p]);
         send_idle_pct = phase_idle[p % 4];
         rsp_stall_pct = phase_stall[p % 4];
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) begin
            if ($urandom_range(39) == 0) drain();
            send_frame();
         end
      end
      drain();
      $display("Sent %0d bytes under six length limits, %0d of them inside frames.",
               bytes_sent, framed_bytes);
      $display("Checked %0d payload words, %0d good, %0d bad and %0d dropped frames.",
               kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d words still expected.", expected_words.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
src/shp_pkg.sv
src/shp_core.sv
src/shp_out_reg.sv
src/sync_header_frame_parser.sv
tb/sync_header_frame_parser_tb.sv
